>>> rtl/core/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg: shared definitions for the scaled calendar clock
// Field widths, register indexes, calendar limits and the month length table.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

	localparam int unsigned YEAR_W   = 16;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MIN_W    = 6;
	localparam int unsigned SEC_W    = 6;
	localparam int unsigned SCALE_W  = 16;
	localparam int unsigned ELAP_W   = 16;
	localparam int unsigned PROD_W   = SCALE_W + ELAP_W;
	localparam int unsigned FRAC_W   = 18;
	localparam int unsigned PEND_W   = 20;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned OUT_DATA_W = 48;
	localparam int unsigned OUT_USER_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_YEAR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_MONTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_DAY    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_HOUR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_MINUTE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_START_SECOND = 3'd6;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam logic [SCALE_W-1:0] SCALE_ONE     = 16'd256;
	localparam logic [MIN_W-1:0]   LAST_MINUTE   = 6'd59;
	localparam logic [SEC_W-1:0]   LAST_SECOND   = 6'd59;
	localparam logic [HOUR_W-1:0]  LAST_HOUR     = 5'd23;
	localparam logic [MONTH_W-1:0] LAST_MONTH    = 4'd12;
	localparam logic [PEND_W-1:0]  SECS_PER_MIN  = 20'd60;
	localparam logic [PEND_W-1:0]  PEND_MAX      = {PEND_W{1'b1}};

	typedef struct packed {
		logic [SEC_W-1:0]   second;
		logic [MIN_W-1:0]   minute;
		logic [HOUR_W-1:0]  hour;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} cal_t;

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] d;
		unique case (m)
			4'd2:                    d = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default:                 d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/scaled_calendar_clock.sv
// ----------------------------------------------------------------------------
// scaled_calendar_clock: calendar clock driven by scaled elapsed-time ticks
// Scales each tick, accumulates seconds and steps the calendar per minute, or loads the start time.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item: tuser[0] is the operation (tick or load),
//   tdata[15:0] the elapsed time in 1/1024 s. m_axis returns results: a tick
//   gives one result per minute rollover, then a final result with tlast set;
//   a load gives the final result only. cfg writes the seven registers by
//   index and is always ready; write it only while the block is idle.
//   A tick passes from idle through multiply and accumulate, then steps the
//   calendar once per result through the single calendar step unit; a load
//   goes from idle straight to the step unit. The next item is accepted only
//   after the final result is registered. s_axis_tready is high only in idle.
//   A stalled receiver holds the output register and halts the step unit;
//   no result is lost. Reset clears the calendar, accumulator and pending
//   seconds, and returns the registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_calendar_clock
	import scc_pkg::*;
#(
	parameter int unsigned MAX_ROLLOVERS = 63
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire [ELAP_W-1:0]       s_axis_tdata,   // [15:0] elapsed
	input  wire                    s_axis_tuser,   // [0] operation
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // year, month, day, hour, minute, second
	output logic [OUT_USER_W-1:0]  m_axis_tuser,   // minute_event, date_event, overflow
	output logic                   m_axis_tlast,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire [CFG_IDX_W-1:0]    cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned CNT_W = $clog2(MAX_ROLLOVERS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ROLLOVERS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;
	localparam logic [1:0] ST_ROLL = 2'd3;

	logic [1:0]           state_q;
	logic [SCALE_W-1:0]   scale_q;
	cal_t                 start_q;
	logic [ELAP_W-1:0]    elapsed_q;
	logic [PROD_W-1:0]    prod_q;
	logic [FRAC_W-1:0]    frac_q;
	logic [PEND_W-1:0]    pend_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 load_q;
	logic                 ovf_q;
	cal_t                 cal_q;
	logic                 m_valid_q;
	cal_t                 m_cal_q;
	logic                 m_mev_q;
	logic                 m_dev_q;
	logic                 m_ovf_q;
	logic                 m_last_q;

	logic                 s_accept;
	logic                 out_free;
	logic                 do_roll;
	logic [PROD_W:0]      sum;
	logic [PEND_W:0]      pend_sum;
	cal_t                 cal_next;
	logic                 date_adv;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign do_roll       = !load_q && (cnt_q < CNT_MAX) && (pend_q >= SECS_PER_MIN);

	assign sum      = {1'b0, prod_q} + (PROD_W + 1)'(frac_q);
	assign pend_sum = {1'b0, pend_q} + (PEND_W + 1)'(sum[PROD_W:FRAC_W]);

	// calendar step unit: one minute rollover
	always_comb begin
		cal_next = cal_q;
		date_adv = 1'b0;
		if (cal_q.minute < LAST_MINUTE) begin
			cal_next.minute = cal_q.minute + 1'b1;
		end else begin
			cal_next.minute = '0;
			if (cal_q.hour < LAST_HOUR) begin
				cal_next.hour = cal_q.hour + 1'b1;
			end else begin
				cal_next.hour = '0;
				date_adv = 1'b1;
				if (cal_q.day >= month_days(cal_q.month)) begin
					cal_next.day = DAY_W'(1);
					if (cal_q.month >= LAST_MONTH) begin
						cal_next.month = MONTH_W'(1);
						cal_next.year  = cal_q.year + 1'b1;
					end else begin
						cal_next.month = cal_q.month + 1'b1;
					end
				end else begin
					cal_next.day = cal_q.day + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q        <= SCALE_ONE;
			start_q.year   <= '0;
			start_q.month  <= MONTH_W'(1);
			start_q.day    <= DAY_W'(1);
			start_q.hour   <= '0;
			start_q.minute <= '0;
			start_q.second <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TIME_SCALE:   scale_q        <= cfg_data;
				REG_START_YEAR:   start_q.year   <= cfg_data;
				REG_START_MONTH:  start_q.month  <= cfg_data[MONTH_W-1:0];
				REG_START_DAY:    start_q.day    <= cfg_data[DAY_W-1:0];
				REG_START_HOUR:   start_q.hour   <= cfg_data[HOUR_W-1:0];
				REG_START_MINUTE: start_q.minute <= cfg_data[MIN_W-1:0];
				REG_START_SECOND: start_q.second <= cfg_data[SEC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			frac_q     <= '0;
			pend_q     <= '0;
			cnt_q      <= '0;
			load_q     <= 1'b0;
			ovf_q      <= 1'b0;
			cal_q.year   <= '0;
			cal_q.month  <= MONTH_W'(1);
			cal_q.day    <= DAY_W'(1);
			cal_q.hour   <= '0;
			cal_q.minute <= '0;
			cal_q.second <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_ROLL && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						ovf_q  <= 1'b0;
						cnt_q  <= '0;
						load_q <= (s_axis_tuser == OP_LOAD);
						if (s_axis_tuser == OP_LOAD) begin
							cal_q  <= start_q;
							pend_q <= PEND_W'(start_q.second);
							state_q <= ST_ROLL;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					frac_q <= sum[FRAC_W-1:0];
					if (pend_sum[PEND_W]) begin
						pend_q <= PEND_MAX;
						ovf_q  <= 1'b1;
					end else begin
						pend_q <= pend_sum[PEND_W-1:0];
					end
					state_q <= ST_ROLL;
				end
				ST_ROLL: begin
					if (out_free) begin
						if (do_roll) begin
							pend_q <= pend_q - SECS_PER_MIN;
							cal_q  <= cal_next;
							cnt_q  <= cnt_q + 1'b1;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the elapsed operand, the product and the output payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			elapsed_q <= s_axis_tdata;
		end
		if (state_q == ST_MUL) begin
			prod_q <= elapsed_q * scale_q;
		end
		if (state_q == ST_ROLL && out_free) begin
			m_ovf_q <= ovf_q;
			if (do_roll) begin
				m_cal_q  <= {{SEC_W{1'b0}}, cal_next[$bits(cal_t)-SEC_W-1:0]};
				m_mev_q  <= 1'b1;
				m_dev_q  <= date_adv;
				m_last_q <= 1'b0;
			end else begin
				m_cal_q  <= {((pend_q >= SECS_PER_MIN) ? LAST_SECOND : pend_q[SEC_W-1:0]),
					cal_q[$bits(cal_t)-SEC_W-1:0]};
				m_mev_q  <= 1'b0;
				m_dev_q  <= 1'b0;
				m_last_q <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, m_cal_q};
	assign m_axis_tuser  = {m_ovf_q, m_dev_q, m_mev_q};
	assign m_axis_tlast  = m_last_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("rollover count past limit");

	a_last_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tlast && m_axis_tuser[0]))
		else $error("final result flagged as rollover");

	a_date_midnight: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |->
			(m_axis_tdata[35:30] == '0 && m_axis_tdata[29:25] == '0))
		else $error("date advanced away from midnight");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_axis_tready)
		else $error("item accepted while sequencer stayed idle");
`endif

endmodule

`default_nettype wire
